### src/edf_pkg.sv
// ----------------------------------------------------------------------------
// edf_pkg
// Shared types and constants for the earliest-deadline-first task table.
// ----------------------------------------------------------------------------
package edf_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int TIME_BITS   = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam logic [15:0] MISS_MAX = 16'hFFFF;

    typedef logic [TIME_BITS-1:0] time_t;

    // one table slot as stored in memory
    typedef struct packed {
        logic [7:0]  task_id;
        time_t       deadline;
        time_t       period;
        logic [31:0] exec_ms;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [1:0] {
        REQ_CREATE = 2'd0,
        REQ_DONE   = 2'd1,
        REQ_TICK   = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

endpackage

### src/edf_ram.sv
// ----------------------------------------------------------------------------
// edf_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module edf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### src/edf_deadline_task_table.sv
// ----------------------------------------------------------------------------
// edf_deadline_task_table
// Active task table kept sorted by absolute deadline, earliest first.
// ----------------------------------------------------------------------------
// A request is taken on a clock edge with start high and busy low. The
// request fields are captured then and need not be held. One result comes
// back per request: the result ports carry it for exactly one cycle, marked
// by done, and the receiver cannot stall it.
//
// All task slots live in one memory with a registered read. The
// table is walked one slot per cycle, reading one slot and writing the
// neighbor slot in the same cycle, so each request is a single pass:
//   create      : backward shift from the tail
//   completion  : forward scan, closing the gap
//   tick        : head deadline check, then a forward shift on a miss
//   other codes : head report only
// Every request ends with a read of slot 0 to report the head. done rises
// on the edge where busy falls, and a new request can be taken in that
// cycle.
//
// Reset clears the task count, the miss counter and the control state; the
// memory contents are not cleared, only slots below the count are used.
// ----------------------------------------------------------------------------
module edf_deadline_task_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [7:0]  task_id,
    input  logic [31:0] abs_deadline,
    input  logic [31:0] period_ms,
    input  logic [31:0] exec_ms,
    input  logic [31:0] now_ms,
    output logic        done,
    output logic [1:0]  status,
    output logic        head_valid,
    output logic [7:0]  head_task,
    output logic [31:0] head_deadline,
    output logic        missed,
    output logic [7:0]  missed_task,
    output logic [15:0] overdue_count,
    output logic [4:0]  active_count
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_DEL,
        S_TCK0,
        S_TCK,
        S_WR_NEW,
        S_HEAD,
        S_OUT
    } state_t;

    state_t                         state_reg, state_next;
    logic [edf_pkg::IDX_W-1:0]      idx_reg, idx_next;
    logic [edf_pkg::IDX_W-1:0]      pos_reg, pos_next;
    logic [edf_pkg::CNT_W-1:0]      count_reg, count_next;
    logic                           found_reg, found_next;
    edf_pkg::entry_t                new_reg, new_next;
    logic [7:0]                     id_reg, id_next;
    edf_pkg::time_t                 now_reg, now_next;
    edf_pkg::status_t               stat_reg, stat_next;
    logic [15:0]                    miss_reg, miss_next;
    logic                           missed_reg, missed_next;
    logic [7:0]                     mtask_reg, mtask_next;

    logic                           done_reg;
    logic [1:0]                     status_reg;
    logic                           head_valid_reg;
    logic [7:0]                     head_task_reg;
    logic [31:0]                    head_dl_reg;

    // memory port controls
    logic                           we;
    logic [edf_pkg::IDX_W-1:0]      wr_addr;
    edf_pkg::entry_t                wr_data;
    logic [edf_pkg::IDX_W-1:0]      rd_addr;
    logic [edf_pkg::ENTRY_W-1:0]    rd_raw;
    edf_pkg::entry_t                rd_entry;

    logic [edf_pkg::IDX_W-1:0]      last_idx;
    logic                           at_last;
    logic                           id_hit;

    edf_ram #(
        .WIDTH (edf_pkg::ENTRY_W),
        .DEPTH (edf_pkg::TABLE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    assign rd_entry = edf_pkg::entry_t'(rd_raw);
    assign last_idx = edf_pkg::IDX_W'(count_reg - edf_pkg::CNT_W'(1));
    assign at_last  = (edf_pkg::CNT_W'(idx_reg) + edf_pkg::CNT_W'(1)) == count_reg;
    assign id_hit   = rd_entry.task_id == id_reg;

    // request sequencer: one slot per cycle through the memory
    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        count_next  = count_reg;
        found_next  = found_reg;
        new_next    = new_reg;
        id_next     = id_reg;
        now_next    = now_reg;
        stat_next   = stat_reg;
        miss_next   = miss_reg;
        missed_next = missed_reg;
        mtask_next  = mtask_reg;
        we          = 1'b0;
        wr_addr     = idx_reg;
        wr_data     = new_reg;
        rd_addr     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    new_next.task_id   = task_id;
                    new_next.deadline  = edf_pkg::time_t'(abs_deadline);
                    new_next.period    = edf_pkg::time_t'(period_ms);
                    new_next.exec_ms   = exec_ms;
                    id_next     = task_id;
                    now_next    = edf_pkg::time_t'(now_ms);
                    stat_next   = edf_pkg::ST_OK;
                    missed_next = 1'b0;
                    mtask_next  = '0;
                    found_next  = 1'b0;
                    idx_next    = '0;
                    state_next  = S_HEAD;
                    case (req_type)
                        edf_pkg::REQ_CREATE:
                        begin
                            if (count_reg == edf_pkg::CNT_W'(edf_pkg::TABLE_DEPTH))
                            begin
                                stat_next = edf_pkg::ST_FULL;
                            end
                            else if (count_reg == '0)
                            begin
                                count_next = count_reg + edf_pkg::CNT_W'(1);
                                pos_next   = '0;
                                state_next = S_WR_NEW;
                            end
                            else
                            begin
                                count_next = count_reg + edf_pkg::CNT_W'(1);
                                rd_addr    = last_idx;
                                idx_next   = last_idx;
                                state_next = S_INS;
                            end
                        end
                        edf_pkg::REQ_DONE:
                        begin
                            if (count_reg == '0)
                            begin
                                stat_next = edf_pkg::ST_NOT_FOUND;
                            end
                            else
                            begin
                                rd_addr    = '0;
                                state_next = S_DEL;
                            end
                        end
                        edf_pkg::REQ_TICK:
                        begin
                            if (count_reg != '0)
                            begin
                                rd_addr    = '0;
                                state_next = S_TCK0;
                            end
                        end
                        default:
                        begin
                            state_next = S_HEAD;
                        end
                    endcase
                end
            end

            // walk backward from the tail, moving later deadlines up one slot
            S_INS:
            begin
                if (rd_entry.deadline > new_reg.deadline)
                begin
                    we      = 1'b1;
                    wr_addr = idx_reg + edf_pkg::IDX_W'(1);
                    wr_data = rd_entry;
                    if (idx_reg == '0)
                    begin
                        pos_next   = '0;
                        state_next = S_WR_NEW;
                    end
                    else
                    begin
                        rd_addr  = idx_reg - edf_pkg::IDX_W'(1);
                        idx_next = idx_reg - edf_pkg::IDX_W'(1);
                    end
                end
                else
                begin
                    we         = 1'b1;
                    wr_addr    = idx_reg + edf_pkg::IDX_W'(1);
                    wr_data    = new_reg;
                    state_next = S_HEAD;
                end
            end

            // scan forward for the id, pulling later slots down once found
            S_DEL:
            begin
                if (found_reg)
                begin
                    we      = 1'b1;
                    wr_addr = idx_reg - edf_pkg::IDX_W'(1);
                    wr_data = rd_entry;
                end
                else if (id_hit)
                begin
                    found_next = 1'b1;
                end
                if (at_last)
                begin
                    if (found_reg || id_hit)
                    begin
                        count_next = count_reg - edf_pkg::CNT_W'(1);
                    end
                    else
                    begin
                        stat_next = edf_pkg::ST_NOT_FOUND;
                    end
                    state_next = S_HEAD;
                end
                else
                begin
                    rd_addr  = idx_reg + edf_pkg::IDX_W'(1);
                    idx_next = idx_reg + edf_pkg::IDX_W'(1);
                end
            end

            // head deadline check; a miss re-releases the head one period later
            S_TCK0:
            begin
                if (now_reg >= rd_entry.deadline)
                begin
                    missed_next        = 1'b1;
                    mtask_next         = rd_entry.task_id;
                    if (miss_reg != edf_pkg::MISS_MAX)
                    begin
                        miss_next = miss_reg + 16'd1;
                    end
                    new_next           = rd_entry;
                    new_next.deadline  = rd_entry.deadline + rd_entry.period;
                    if (count_reg == edf_pkg::CNT_W'(1))
                    begin
                        pos_next   = '0;
                        state_next = S_WR_NEW;
                    end
                    else
                    begin
                        rd_addr    = edf_pkg::IDX_W'(1);
                        idx_next   = edf_pkg::IDX_W'(1);
                        state_next = S_TCK;
                    end
                end
                else
                begin
                    state_next = S_HEAD;
                end
            end

            // move earlier-or-equal deadlines down until the new one fits
            S_TCK:
            begin
                we      = 1'b1;
                wr_addr = idx_reg - edf_pkg::IDX_W'(1);
                if (rd_entry.deadline <= new_reg.deadline)
                begin
                    wr_data = rd_entry;
                    if (at_last)
                    begin
                        pos_next   = idx_reg;
                        state_next = S_WR_NEW;
                    end
                    else
                    begin
                        rd_addr  = idx_reg + edf_pkg::IDX_W'(1);
                        idx_next = idx_reg + edf_pkg::IDX_W'(1);
                    end
                end
                else
                begin
                    wr_data    = new_reg;
                    state_next = S_HEAD;
                end
            end

            S_WR_NEW:
            begin
                we         = 1'b1;
                wr_addr    = pos_reg;
                wr_data    = new_reg;
                state_next = S_HEAD;
            end

            // read the head slot for the report
            S_HEAD:
            begin
                rd_addr    = '0;
                state_next = S_OUT;
            end

            S_OUT:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state, datapath and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            miss_reg       <= '0;
            done_reg       <= 1'b0;
            found_reg      <= 1'b0;
            idx_reg        <= '0;
            pos_reg        <= '0;
            stat_reg       <= edf_pkg::ST_OK;
            missed_reg     <= 1'b0;
            mtask_reg      <= '0;
            status_reg     <= '0;
            head_valid_reg <= 1'b0;
            head_task_reg  <= '0;
            head_dl_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            miss_reg   <= miss_next;
            found_reg  <= found_next;
            idx_reg    <= idx_next;
            pos_reg    <= pos_next;
            stat_reg   <= stat_next;
            missed_reg <= missed_next;
            mtask_reg  <= mtask_next;
            done_reg   <= (state_reg == S_OUT);
            if (state_reg == S_OUT)
            begin
                status_reg     <= stat_reg;
                head_valid_reg <= count_reg != '0;
                head_task_reg  <= (count_reg != '0) ? rd_entry.task_id : 8'd0;
                head_dl_reg    <= (count_reg != '0) ? 32'(rd_entry.deadline) : 32'd0;
            end
        end
    end

    // request payload, no reset needed
    always_ff @(posedge clk)
    begin
        new_reg <= new_next;
        id_reg  <= id_next;
        now_reg <= now_next;
    end

    assign busy          = state_reg != S_IDLE;
    assign done          = done_reg;
    assign status        = status_reg;
    assign head_valid    = head_valid_reg;
    assign head_task     = head_task_reg;
    assign head_deadline = head_dl_reg;
    assign missed        = done_reg & missed_reg;
    assign missed_task   = done_reg ? mtask_reg : 8'd0;
    assign overdue_count = miss_reg;
    assign active_count  = 5'(count_reg);

endmodule

### tb/edf_task_table_checker.sv
// ----------------------------------------------------------------------------
// edf_task_table_checker
// Watches the request and result ports of the deadline task table, predicts
// the head report of each request and compares the results field by field.
// ----------------------------------------------------------------------------
module edf_task_table_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  req_type,
    input  logic [7:0]  task_id,
    input  logic [31:0] abs_deadline,
    input  logic [31:0] period_ms,
    input  logic [31:0] exec_ms,
    input  logic [31:0] now_ms,
    input  logic        done,
    input  logic [1:0]  status,
    input  logic        head_valid,
    input  logic [7:0]  head_task,
    input  logic [31:0] head_deadline,
    input  logic        missed,
    input  logic [7:0]  missed_task,
    input  logic [15:0] overdue_count,
    input  logic [4:0]  active_count,
    output int          fail_count,
    output int          pending
);

    localparam int REPORT_LIMIT = 10;

    // head report that one request leaves behind
    typedef struct packed {
        logic [1:0]  status;
        logic        head_valid;
        logic [7:0]  head_task;
        logic [31:0] head_deadline;
        logic        missed;
        logic [7:0]  missed_task;
        logic [15:0] overdue_count;
        logic [4:0]  active_count;
    } head_report_t;

    // shadow of the sorted task table
    edf_pkg::entry_t task_slot [edf_pkg::TABLE_DEPTH];
    int              task_total;
    logic [15:0]     miss_total;
    head_report_t    head_reports [$];
    int              result_seq;

    // stable insert behind every task with an equal or earlier deadline
    task automatic insert_task(input edf_pkg::entry_t item);
        int pos;
        pos = 0;
        while (pos < task_total && task_slot[pos].deadline <= item.deadline)
            pos++;
        for (int i = task_total; i > pos; i--)
            task_slot[i] = task_slot[i - 1];
        task_slot[pos] = item;
        task_total++;
    endtask

    // remove one slot and close the gap
    task automatic remove_slot(input int pos);
        for (int i = pos; i + 1 < task_total; i++)
            task_slot[i] = task_slot[i + 1];
        task_total--;
    endtask

    // apply one request to the shadow table and build its head report
    task automatic predict_head(
        input  logic [1:0]     code,
        input  logic [7:0]     id,
        input  edf_pkg::time_t dl,
        input  edf_pkg::time_t per,
        input  logic [31:0]    ex,
        input  edf_pkg::time_t now,
        output head_report_t   rpt
    );
        edf_pkg::entry_t item;
        int              hit;
        rpt = '0;
        rpt.status = edf_pkg::ST_OK;
        hit = -1;
        case (edf_pkg::req_t'(code))
            edf_pkg::REQ_CREATE:
            begin
                if (task_total >= edf_pkg::TABLE_DEPTH)
                begin
                    rpt.status = edf_pkg::ST_FULL;
                end
                else
                begin
                    item.task_id  = id;
                    item.deadline = dl;
                    item.period   = per;
                    item.exec_ms  = ex;
                    insert_task(item);
                end
            end
            edf_pkg::REQ_DONE:
            begin
                for (int i = 0; i < task_total; i++)
                    if (hit < 0 && task_slot[i].task_id == id)
                        hit = i;
                if (hit < 0)
                    rpt.status = edf_pkg::ST_NOT_FOUND;
                else
                    remove_slot(hit);
            end
            edf_pkg::REQ_TICK:
            begin
                // overdue head goes back in one period later, wrapping
                if (task_total > 0 && now >= task_slot[0].deadline)
                begin
                    item = task_slot[0];
                    rpt.missed      = 1'b1;
                    rpt.missed_task = item.task_id;
                    if (miss_total != edf_pkg::MISS_MAX)
                        miss_total++;
                    remove_slot(0);
                    item.deadline = item.deadline + item.period;
                    insert_task(item);
                end
            end
            default:
            begin
            end
        endcase
        if (task_total > 0)
        begin
            rpt.head_valid    = 1'b1;
            rpt.head_task     = task_slot[0].task_id;
            rpt.head_deadline = 32'(task_slot[0].deadline);
        end
        rpt.overdue_count = miss_total;
        rpt.active_count  = 5'(task_total);
    endtask

    task automatic compare_field(
        input string       name,
        input logic [31:0] want,
        input logic [31:0] got
    );
        if (want !== got)
        begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("result %0d: %s expected %0h, got %0h", result_seq, name, want, got);
        end
    endtask

    // results are checked before a request taken on the same edge is predicted
    always @(posedge clk or negedge rst_n)
    begin : watch
        head_report_t want;
        if (!rst_n)
        begin
            task_total = 0;
            miss_total = '0;
            head_reports.delete();
            result_seq = 0;
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (done)
            begin
                if (head_reports.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("result %0d: no request outstanding, status %0h head %0h",
                                 result_seq, status, head_task);
                end
                else
                begin
                    want = head_reports.pop_front();
                    compare_field("status", 32'(want.status), 32'(status));
                    compare_field("head_valid", 32'(want.head_valid), 32'(head_valid));
                    compare_field("head_task", 32'(want.head_task), 32'(head_task));
                    compare_field("head_deadline", want.head_deadline, head_deadline);
                    compare_field("missed", 32'(want.missed), 32'(missed));
                    compare_field("missed_task", 32'(want.missed_task), 32'(missed_task));
                    compare_field("overdue_count", 32'(want.overdue_count),
                                  32'(overdue_count));
                    compare_field("active_count", 32'(want.active_count), 32'(active_count));
                end
                result_seq++;
            end
            if (start && !busy)
            begin
                predict_head(req_type, task_id, abs_deadline, period_ms, exec_ms,
                             now_ms, want);
                head_reports.push_back(want);
            end
            pending = head_reports.size();
        end
    end

endmodule

### tb/edf_deadline_task_table_test.sv
// ----------------------------------------------------------------------------
// edf_deadline_task_table_test
// Drives create, completion, tick and unused-code requests into the deadline
// task table: a directed opening, then random fill and drain episodes sent
// in bursts with gaps.
// ----------------------------------------------------------------------------
module edf_deadline_task_table_test;

    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int RANDOM_REQUESTS = 500;
    localparam int DRAIN_CYCLES    = 40;
    localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  req_type = edf_pkg::REQ_CREATE;
    logic [7:0]  task_id = '0;
    logic [31:0] abs_deadline = '0;
    logic [31:0] period_ms = '0;
    logic [31:0] exec_ms = '0;
    logic [31:0] now_ms = '0;
    logic        done;
    logic [1:0]  status;
    logic        head_valid;
    logic [7:0]  head_task;
    logic [31:0] head_deadline;
    logic        missed;
    logic [7:0]  missed_task;
    logic [15:0] overdue_count;
    logic [4:0]  active_count;
    int          fail_count;
    int          pending;

    int          idle_cycles = 0;
    logic [31:0] sim_clock = '0;
    logic [7:0]  created_ids [$];
    int          burst_left;
    int          sent;
    bit          filling;

    edf_deadline_task_table dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .task_id       (task_id),
        .abs_deadline  (abs_deadline),
        .period_ms     (period_ms),
        .exec_ms       (exec_ms),
        .now_ms        (now_ms),
        .done          (done),
        .status        (status),
        .head_valid    (head_valid),
        .head_task     (head_task),
        .head_deadline (head_deadline),
        .missed        (missed),
        .missed_task   (missed_task),
        .overdue_count (overdue_count),
        .active_count  (active_count)
    );

    edf_task_table_checker table_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .task_id       (task_id),
        .abs_deadline  (abs_deadline),
        .period_ms     (period_ms),
        .exec_ms       (exec_ms),
        .now_ms        (now_ms),
        .done          (done),
        .status        (status),
        .head_valid    (head_valid),
        .head_task     (head_task),
        .head_deadline (head_deadline),
        .missed        (missed),
        .missed_task   (missed_task),
        .overdue_count (overdue_count),
        .active_count  (active_count),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // watchdog on cycles with neither a request nor a result
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("edf_deadline_task_table: mismatch");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // present one request and hold it until the table takes it
    task automatic send_request(
        input edf_pkg::req_t code,
        input logic [7:0]    id,
        input logic [31:0]   dl,
        input logic [31:0]   per,
        input logic [31:0]   ex,
        input logic [31:0]   now
    );
        start        <= 1'b1;
        req_type     <= code;
        task_id      <= id;
        abs_deadline <= dl;
        period_ms    <= per;
        exec_ms      <= ex;
        now_ms       <= now;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic hold_off(input int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // one random request; filling episodes lean on creates, draining ones on removals
    task automatic random_request(input bit fill_mode);
        int             pick;
        int             idx;
        edf_pkg::req_t  code;
        logic [7:0]     id;
        logic [31:0]    dl;
        logic [31:0]    per;
        logic [31:0]    now;
        pick = $urandom_range(0, 99);
        if (fill_mode)
            code = pick < 55 ? edf_pkg::REQ_CREATE : pick < 72 ? edf_pkg::REQ_DONE :
                   pick < 96 ? edf_pkg::REQ_TICK : edf_pkg::REQ_NONE;
        else
            code = pick < 15 ? edf_pkg::REQ_CREATE : pick < 55 ? edf_pkg::REQ_DONE :
                   pick < 96 ? edf_pkg::REQ_TICK : edf_pkg::REQ_NONE;

        id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
        // removals mostly name a task that was created
        if (code == edf_pkg::REQ_DONE && created_ids.size() > 0 && $urandom_range(0, 3) != 0)
        begin
            idx = $urandom_range(0, created_ids.size() - 1);
            id  = created_ids[idx];
            created_ids.delete(idx);
        end
        if (code == edf_pkg::REQ_CREATE)
            created_ids.push_back(id);

        pick = $urandom_range(0, 19);
        if (pick < 2)
            dl = $urandom;
        else if (pick == 2)
            dl = TIME_MAX - $urandom_range(0, 100);
        else
            dl = sim_clock + $urandom_range(0, 80);
        per = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 40);

        // ticks move the time base forward
        if (code == edf_pkg::REQ_TICK)
            sim_clock = sim_clock + $urandom_range(0, 12);
        pick = $urandom_range(0, 19);
        if (pick == 0)
            now = TIME_MAX;
        else if (pick < 3)
            now = $urandom;
        else
            now = sim_clock;

        send_request(code, id, dl, per, $urandom, now);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, unknown id, unused code
        send_request(edf_pkg::REQ_TICK, 8'h00, '0, '0, '0, TIME_MAX);
        send_request(edf_pkg::REQ_DONE, 8'hFF, '0, '0, '0, '0);
        send_request(edf_pkg::REQ_NONE, 8'hFF, TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX);

        // creates with ties and a duplicate id
        send_request(edf_pkg::REQ_CREATE, 8'h00, 32'd100, 32'd100, '0, '0);
        send_request(edf_pkg::REQ_CREATE, 8'hFF, TIME_MAX, TIME_MAX, TIME_MAX, '0);
        send_request(edf_pkg::REQ_CREATE, 8'h05, 32'd100, 32'd7, 32'h1234_5678, '0);
        hold_off(3);
        send_request(edf_pkg::REQ_CREATE, 8'h05, 32'd50, 32'd9, 32'h8765_4321, '0);
        send_request(edf_pkg::REQ_DONE, 8'h05, '0, '0, '0, '0);

        // ticks just before, at and well past the head deadline
        send_request(edf_pkg::REQ_TICK, 8'h00, '0, '0, '0, 32'd99);
        send_request(edf_pkg::REQ_TICK, 8'h00, '0, '0, '0, 32'd100);
        hold_off(1);
        send_request(edf_pkg::REQ_TICK, 8'h00, '0, '0, '0, TIME_MAX);
        send_request(edf_pkg::REQ_TICK, 8'h00, '0, '0, '0, '0);

        // a lone far-off task whose re-release wraps
        send_request(edf_pkg::REQ_DONE, 8'h00, '0, '0, '0, '0);
        send_request(edf_pkg::REQ_DONE, 8'h05, '0, '0, '0, '0);
        send_request(edf_pkg::REQ_TICK, 8'h00, '0, '0, '0, TIME_MAX);

        // zero deadline and zero period miss at time zero
        send_request(edf_pkg::REQ_CREATE, 8'hA5, '0, '0, 32'hA5A5_A5A5, '0);
        send_request(edf_pkg::REQ_TICK, 8'h00, '0, '0, '0, '0);
        send_request(edf_pkg::REQ_DONE, 8'hA5, '0, '0, '0, '0);
        send_request(edf_pkg::REQ_DONE, 8'hFF, '0, '0, '0, '0);

        // random fill and drain episodes, sent in bursts
        sent       = 0;
        filling    = 1'b0;
        burst_left = 1;
        while (sent < RANDOM_REQUESTS)
        begin
            filling = !filling;
            repeat ($urandom_range(10, 40))
            begin
                random_request(filling);
                sent++;
                burst_left--;
                if (burst_left <= 0)
                begin
                    hold_off($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12));
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                             : $urandom_range(1, 8);
                end
            end
        end

        // let the last results come back
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("edf_deadline_task_table: match");
        else
            $display("edf_deadline_task_table: mismatch");
        $finish;
    end

endmodule

### edf_deadline_task_table.f
src/edf_pkg.sv
src/edf_ram.sv
src/edf_deadline_task_table.sv
tb/edf_task_table_checker.sv
tb/edf_deadline_task_table_test.sv
